/* rtl/core/pipwt_pkg.sv */
`default_nettype none
package pipwt_pkg;

  localparam int COORD_W    = 32;
  localparam int WIND_W     = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_EDGES  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_QUERY_X    = 2'd0;
  localparam cfg_idx_t CFG_QUERY_Y    = 2'd1;
  localparam cfg_idx_t CFG_FILL_RULE  = 2'd2;
  localparam cfg_idx_t CFG_PATH_VALID = 2'd3;

  localparam logic FILL_NONZERO  = 1'b0;
  localparam logic FILL_EVEN_ODD = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/pipwt_in_if.sv */
`default_nettype none
interface pipwt_in_if;
  import pipwt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  vertex_x;
  logic signed [COORD_W-1:0]  vertex_y;
  logic                       contour_first;
  logic                       contour_last;
  logic                       contour_closed;
  logic                       path_last;

  modport source (
    output valid, vertex_x, vertex_y, contour_first, contour_last, contour_closed,
           path_last,
    input  ready
  );

  modport sink (
    input  valid, vertex_x, vertex_y, contour_first, contour_last, contour_closed,
           path_last,
    output ready
  );

endinterface
`default_nettype wire

/* rtl/core/pipwt_out_if.sv */
`default_nettype none
interface pipwt_out_if;
  import pipwt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      inside_res;
  logic signed [WIND_W-1:0]  winding_number;
  logic                      crossing_parity;

  modport source (
    output valid, inside_res, winding_number, crossing_parity,
    input  ready
  );

  modport sink (
    input  valid, inside_res, winding_number, crossing_parity,
    output ready
  );

endinterface
`default_nettype wire

/* rtl/core/point_in_path_winding_test.sv */
// Point-in-path test, streamed vertices, even-odd and nonzero winding rules.
// A result beat passes through stages 1, 2 and 3 and then the result register after the path_last vertex beat.
// Throughput: one vertex per cycle unless a path result waits on a stalled output; edge and
// closing-edge tests run in parallel through a select/subtract stage and a multiply stage.
// Reset (synchronous, rst_n low): pipeline empty, accumulators and contour
// state cleared, query point 0, nonzero rule, path valid.
`default_nettype none
module point_in_path_winding_test #(
  parameter int COORD_BITS = 32,
  parameter int MAX_POINTS = 131072
) (
  input  wire                                clk,
  input  wire                                rst_n,
  pipwt_in_if.sink                           in_ch,
  pipwt_out_if.source                        out_ch,
  input  wire                                cfg_we,
  input  wire [pipwt_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire [pipwt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pipwt_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int WIND_LIMIT = (MAX_POINTS < 262143) ? MAX_POINTS : 262143;
  localparam logic signed [WIND_W-1:0] WMAX = WIND_W'(WIND_LIMIT);
  localparam logic signed [WIND_W-1:0] WMIN = WIND_W'(-WIND_LIMIT);

  // configuration
  logic signed [CW-1:0] qx_r, qy_r;
  logic                 fill_rule_r, path_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r         <= '0;
      qy_r         <= '0;
      fill_rule_r  <= FILL_NONZERO;
      path_valid_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_QUERY_X:    qx_r         <= cfg_wdata[CW-1:0];
        CFG_QUERY_Y:    qy_r         <= cfg_wdata[CW-1:0];
        CFG_FILL_RULE:  fill_rule_r  <= cfg_wdata[0];
        CFG_PATH_VALID: path_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_last_r, s2_last_r, s3_last_r;
  logic cons3, en1, en2, en3, in_acc;

  assign cons3  = !s3_last_r || !out_v_r || out_ch.ready;
  assign en3    = !s3_v_r || cons3;
  assign en2    = !s2_v_r || en3;
  assign en1    = !s1_v_r || en2;
  assign in_acc = in_ch.valid && en1;
  assign in_ch.ready = en1;

  // contour state, updated on accept
  logic signed [CW-1:0] vx, vy;
  logic signed [CW-1:0] prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic signed [CW-1:0] first_x_nxt, first_y_nxt;
  logic                 have_prev_r, start_new;

  assign vx          = in_ch.vertex_x[CW-1:0];
  assign vy          = in_ch.vertex_y[CW-1:0];
  assign start_new   = in_ch.contour_first || !have_prev_r;
  assign first_x_nxt = start_new ? vx : first_x_r;
  assign first_y_nxt = start_new ? vy : first_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      have_prev_r <= 1'b0;
    end else if (in_acc) begin
      prev_x_r    <= vx;
      prev_y_r    <= vy;
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      have_prev_r <= !(in_ch.contour_last || in_ch.path_last);
    end
  end

  // stage 1: edge endpoints. edge 0 is prev->cur, edge 1 the closing edge
  logic                 s1_ev_r [NUM_EDGES];
  logic signed [CW-1:0] s1_sx_r [NUM_EDGES];
  logic signed [CW-1:0] s1_sy_r [NUM_EDGES];
  logic signed [CW-1:0] s1_ex_r [NUM_EDGES];
  logic signed [CW-1:0] s1_ey_r [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r  <= in_ch.path_last;
      s1_ev_r[0] <= !start_new;
      s1_sx_r[0] <= prev_x_r;
      s1_sy_r[0] <= prev_y_r;
      s1_ex_r[0] <= vx;
      s1_ey_r[0] <= vy;
      s1_ev_r[1] <= in_ch.contour_last && in_ch.contour_closed;
      s1_sx_r[1] <= vx;
      s1_sy_r[1] <= vy;
      s1_ex_r[1] <= first_x_nxt;
      s1_ey_r[1] <= first_y_nxt;
    end
  end

  // stage 2: orient, span test, differences
  logic                 s2_ev_r  [NUM_EDGES];
  logic                 s2_up_r  [NUM_EDGES];
  logic signed [DW-1:0] s2_dqy_r [NUM_EDGES];
  logic signed [DW-1:0] s2_dhx_r [NUM_EDGES];
  logic signed [DW-1:0] s2_dqx_r [NUM_EDGES];
  logic signed [DW-1:0] s2_dhy_r [NUM_EDGES];

  logic                 up_c [NUM_EDGES];
  logic                 span_c [NUM_EDGES];
  logic signed [CW-1:0] lx_c [NUM_EDGES];
  logic signed [CW-1:0] ly_c [NUM_EDGES];
  logic signed [CW-1:0] hx_c [NUM_EDGES];
  logic signed [CW-1:0] hy_c [NUM_EDGES];

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      up_c[e]   = s1_ey_r[e] > s1_sy_r[e];
      lx_c[e]   = up_c[e] ? s1_sx_r[e] : s1_ex_r[e];
      ly_c[e]   = up_c[e] ? s1_sy_r[e] : s1_ey_r[e];
      hx_c[e]   = up_c[e] ? s1_ex_r[e] : s1_sx_r[e];
      hy_c[e]   = up_c[e] ? s1_ey_r[e] : s1_sy_r[e];
      span_c[e] = (ly_c[e] <= qy_r) && (hy_c[e] > qy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_last_r <= s1_last_r;
      for (int e = 0; e < NUM_EDGES; e++) begin
        s2_ev_r[e]  <= s1_ev_r[e] && span_c[e];
        s2_up_r[e]  <= up_c[e];
        s2_dqy_r[e] <= $signed({qy_r[CW-1], qy_r}) - $signed({ly_c[e][CW-1], ly_c[e]});
        s2_dhx_r[e] <= $signed({hx_c[e][CW-1], hx_c[e]}) - $signed({lx_c[e][CW-1], lx_c[e]});
        s2_dqx_r[e] <= $signed({qx_r[CW-1], qx_r}) - $signed({lx_c[e][CW-1], lx_c[e]});
        s2_dhy_r[e] <= $signed({hy_c[e][CW-1], hy_c[e]}) - $signed({ly_c[e][CW-1], ly_c[e]});
      end
    end
  end

  // stage 3: cross products
  logic                 s3_ev_r  [NUM_EDGES];
  logic                 s3_up_r  [NUM_EDGES];
  logic signed [PW-1:0] s3_lhs_r [NUM_EDGES];
  logic signed [PW-1:0] s3_rhs_r [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_last_r <= s2_last_r;
      for (int e = 0; e < NUM_EDGES; e++) begin
        s3_ev_r[e]  <= s2_ev_r[e];
        s3_up_r[e]  <= s2_up_r[e];
        s3_lhs_r[e] <= s2_dqy_r[e] * s2_dhx_r[e];
        s3_rhs_r[e] <= s2_dqx_r[e] * s2_dhy_r[e];
      end
    end
  end

  // crossing decision and accumulation, edge 0 before edge 1
  logic signed [WIND_W-1:0] wind_r, wind_nxt;
  logic                     par_r, par_nxt;

  always_comb begin
    wind_nxt = wind_r;
    par_nxt  = par_r;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (s3_ev_r[e] && (s3_lhs_r[e] > s3_rhs_r[e])) begin
        par_nxt = !par_nxt;
        if (s3_up_r[e]) begin
          if (wind_nxt < WMAX) wind_nxt = wind_nxt + WIND_W'(1);
        end else begin
          if (wind_nxt > WMIN) wind_nxt = wind_nxt - WIND_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_r <= '0;
      par_r  <= 1'b0;
    end else if (s3_v_r && cons3) begin
      wind_r <= s3_last_r ? '0 : wind_nxt;
      par_r  <= s3_last_r ? 1'b0 : par_nxt;
    end
  end

  // result register
  logic                     out_inside_r, out_par_r;
  logic signed [WIND_W-1:0] out_wind_r;
  logic                     out_load;

  assign out_load = s3_v_r && s3_last_r && cons3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (path_valid_r) begin
        out_inside_r <= (fill_rule_r == FILL_EVEN_ODD) ? par_nxt : (wind_nxt != '0);
        out_wind_r   <= wind_nxt;
        out_par_r    <= par_nxt;
      end else begin
        out_inside_r <= 1'b0;
        out_wind_r   <= '0;
        out_par_r    <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.inside_res      = out_inside_r;
  assign out_ch.winding_number  = out_wind_r;
  assign out_ch.crossing_parity = out_par_r;

endmodule
`default_nettype wire

/* dv/pip_result_checker.sv */
`timescale 1ns / 1ps
module pip_result_checker #(
  parameter int MAX_POINTS = 131072
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pipwt_in_if                              in_mon,
  pipwt_out_if                             out_mon,
  input  logic                             cfg_we,
  input  pipwt_pkg::cfg_idx_t              cfg_addr,
  input  logic [pipwt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               fail_count,
  output int                               pending_results
);
  import pipwt_pkg::*;

  localparam int WIND_LIMIT = (MAX_POINTS < 262143) ? MAX_POINTS : 262143;
  localparam int PROD_W     = 2 * COORD_W + 4;

  typedef struct {
    logic                     in_shape;
    logic signed [WIND_W-1:0] winding;
    logic                     parity;
  } path_verdict_t;

  path_verdict_t expected_verdicts[$];

  logic signed [COORD_W-1:0] query_x, query_y;
  logic                      fill_rule, path_valid;
  logic signed [COORD_W-1:0] prev_x, prev_y, first_x, first_y;
  int                        winding_acc;
  logic                      parity_acc, have_prev;
  int                        mismatches = 0;

  // +1 / -1 for a directed crossing strictly right of the query point, else 0
  function automatic int edge_crossing(input logic signed [COORD_W-1:0] sx, sy, ex, ey);
    logic signed [COORD_W-1:0] lx, ly, hx, hy;
    logic signed [PROD_W-1:0]  dqy, dhx, dqx, dhy;
    logic                      up;
    up = ey > sy;
    if (up) begin
      lx = sx; ly = sy; hx = ex; hy = ey;
    end else begin
      lx = ex; ly = ey; hx = sx; hy = sy;
    end
    if (!(ly <= query_y && hy > query_y))
      return 0;
    dqy = query_y - ly;
    dhx = hx - lx;
    dqx = query_x - lx;
    dhy = hy - ly;
    if (dqy * dhx > dqx * dhy)
      return up ? 1 : -1;
    return 0;
  endfunction

  task automatic count_crossing(input int dir);
    if (dir != 0) begin
      parity_acc = ~parity_acc;
      if (dir > 0 && winding_acc < WIND_LIMIT)
        winding_acc++;
      else if (dir < 0 && winding_acc > -WIND_LIMIT)
        winding_acc--;
    end
  endtask

  task automatic scan_vertex(input logic signed [COORD_W-1:0] x, y,
                             input logic first, last, closed, plast);
    path_verdict_t v;
    if (first || !have_prev) begin
      first_x   = x;
      first_y   = y;
      have_prev = 1'b1;
    end else begin
      count_crossing(edge_crossing(prev_x, prev_y, x, y));
    end
    prev_x = x;
    prev_y = y;
    if (last) begin
      if (closed)
        count_crossing(edge_crossing(x, y, first_x, first_y));
      have_prev = 1'b0;
    end
    if (plast) begin
      v.in_shape = 1'b0;
      v.winding  = '0;
      v.parity   = 1'b0;
      if (path_valid) begin
        v.in_shape = (fill_rule == FILL_EVEN_ODD) ? parity_acc : (winding_acc != 0);
        v.winding  = winding_acc[WIND_W-1:0];
        v.parity   = parity_acc;
      end
      expected_verdicts.push_back(v);
      winding_acc = 0;
      parity_acc  = 1'b0;
      have_prev   = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    path_verdict_t want;
    if (!rst_n) begin
      query_x     = '0;
      query_y     = '0;
      fill_rule   = FILL_NONZERO;
      path_valid  = 1'b1;
      prev_x      = '0;
      prev_y      = '0;
      first_x     = '0;
      first_y     = '0;
      winding_acc = 0;
      parity_acc  = 1'b0;
      have_prev   = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_QUERY_X:    query_x    = cfg_wdata;
          CFG_QUERY_Y:    query_y    = cfg_wdata;
          CFG_FILL_RULE:  fill_rule  = cfg_wdata[0];
          CFG_PATH_VALID: path_valid = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        scan_vertex(in_mon.vertex_x, in_mon.vertex_y, in_mon.contour_first,
                    in_mon.contour_last, in_mon.contour_closed, in_mon.path_last);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no path pending");
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_mon.inside_res !== want.in_shape) begin
            $error("inside_res: expected %0d, got %0d", want.in_shape, out_mon.inside_res);
            mismatches++;
          end
          if (out_mon.winding_number !== want.winding) begin
            $error("winding_number: expected %0d, got %0d",
                   want.winding, out_mon.winding_number);
            mismatches++;
          end
          if (out_mon.crossing_parity !== want.parity) begin
            $error("crossing_parity: expected %0d, got %0d",
                   want.parity, out_mon.crossing_parity);
            mismatches++;
          end
        end
      end
    end
    pending_results <= expected_verdicts.size();
    fail_count      <= mismatches;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import pipwt_pkg::*;

  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int RANDOM_VERTICES = 1250;
  localparam int DRAIN_CYCLES    = 8;
  localparam int SPIRAL_TURNS    = 40;
  localparam int ONE             = 65536;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending_results;
  int                    cycle_count = 0;
  int                    vertices_sent = 0;
  int                    burst_left = 0;
  logic                  steady = 1'b0;
  logic signed [COORD_W-1:0] cur_qx = '0, cur_qy = '0;

  pipwt_in_if  in_ch ();
  pipwt_out_if out_ch ();

  point_in_path_winding_test u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  pip_result_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result-side stalls: modes held for a random stretch
  initial begin
    int mode, hold, tick;
    out_ch.ready = 1'b0;
    mode = 0;
    hold = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(16, 160);
      end
      hold--;
      tick++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (tick % 4 == 0);
        default: out_ch.ready <= (tick % 16 == 15);
      endcase
    end
  end

  task automatic send_vertex(input logic signed [COORD_W-1:0] x, y,
                             input logic first, last, closed, plast);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0)
      burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.vertex_x       <= x;
    in_ch.vertex_y       <= y;
    in_ch.contour_first  <= first;
    in_ch.contour_last   <= last;
    in_ch.contour_closed <= closed;
    in_ch.path_last      <= plast;
    do @(posedge clk); while (!in_ch.ready);
    vertices_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic signed [COORD_W-1:0] qx, qy,
                            input logic rule, input logic valid);
    write_reg(CFG_QUERY_X, qx);
    write_reg(CFG_QUERY_Y, qy);
    write_reg(CFG_FILL_RULE, 32'(rule));
    write_reg(CFG_PATH_VALID, 32'(valid));
    cfg_we <= 1'b0;
    cur_qx = qx;
    cur_qy = qy;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_query();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return $signed($urandom) >>> 12;
      default: return $urandom;
    endcase
  endfunction

  // snaps onto the query coordinate now and then to hit ties
  function automatic logic signed [COORD_W-1:0] rand_coord(
      input logic signed [COORD_W-1:0] center, input int spread);
    logic signed [COORD_W-1:0] offset;
    if ($urandom_range(0, 5) == 0)
      return center;
    offset = $signed($urandom) >>> (32 - spread);
    return center + offset;
  endfunction

  task automatic send_path();
    int   contours, nv, spread;
    logic first, last, closed, plast;
    contours = $urandom_range(1, 3);
    case ($urandom_range(0, 5))
      0: spread = 2;
      1: spread = 6;
      2: spread = 12;
      3: spread = 20;
      4: spread = 28;
      default: spread = 32;
    endcase
    for (int c = 0; c < contours; c++) begin
      nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
      for (int i = 0; i < nv; i++) begin
        first  = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        last   = (i == nv - 1);
        closed = last ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
        plast  = (c == contours - 1) && last;
        if (plast && $urandom_range(0, 9) == 0)
          last = 1'b0;
        send_vertex(rand_coord(cur_qx, spread), rand_coord(cur_qy, spread),
                    first, last, closed, plast);
      end
    end
  endtask

  // two vertices per turn: with sign 1 the up edge crosses right and the down edge left; sign -1 mirrors this
  task automatic send_winding_spiral(input int sign);
    for (int k = 0; k < SPIRAL_TURNS; k++) begin
      send_vertex(sign * (-2 * k), -1, k == 0, 1'b0, 1'b0, 1'b0);
      send_vertex(sign * (2 * k + 1), 1, 1'b0, 1'b0, 1'b0, k == SPIRAL_TURNS - 1);
    end
  endtask

  initial begin
    int random_goal, phase_end;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_addr             = CFG_QUERY_X;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.vertex_x       = '0;
    in_ch.vertex_y       = '0;
    in_ch.contour_first  = 1'b0;
    in_ch.contour_last   = 1'b0;
    in_ch.contour_closed = 1'b0;
    in_ch.path_last      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // counterclockwise square, corners at +/-ONE
    send_vertex(-ONE, -ONE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex( ONE, -ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex( ONE,  ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(-ONE,  ONE, 1'b0, 1'b1, 1'b1, 1'b1);
    // lone vertex, closed
    send_vertex(C_MAX, C_MIN, 1'b1, 1'b1, 1'b1, 1'b1);
    // horizontal edge on the scan line
    send_vertex(-ONE, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(2 * ONE, 0, 1'b0, 1'b1, 1'b0, 1'b1);
    // contour opened without a first mark
    send_vertex(2 * ONE, -ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(3 * ONE,  ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(-4 * ONE, ONE, 1'b0, 1'b1, 1'b1, 1'b1);
    // path ends inside an open contour
    send_vertex(ONE, -ONE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(ONE,  ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(5 * ONE, 5 * ONE, 1'b0, 1'b0, 1'b1, 1'b1);
    // full-range corners
    send_vertex(C_MIN, C_MIN, 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b0, 1'b1, 1'b1, 1'b1);
    // two nested clockwise squares
    send_vertex(-ONE, -ONE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(-ONE,  ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex( ONE,  ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex( ONE, -ONE, 1'b0, 1'b1, 1'b1, 1'b0);
    send_vertex(-2 * ONE, -2 * ONE, 1'b1, 1'b0, 1'b0, 1'b0);
    send_vertex(-2 * ONE,  2 * ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex( 2 * ONE,  2 * ONE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_vertex( 2 * ONE, -2 * ONE, 1'b0, 1'b1, 1'b1, 1'b1);
    wait_idle();

    // long spirals, both winding signs, each with its vertices sent back to back
    steady = 1'b1;
    send_winding_spiral(1);
    wait_idle();
    send_winding_spiral(-1);
    wait_idle();
    steady = 1'b0;

    random_goal = vertices_sent + RANDOM_VERTICES;
    for (int phase = 0; vertices_sent < random_goal; phase++) begin
      case (phase)
        0: set_config(C_MIN, C_MAX, FILL_EVEN_ODD, 1'b1);
        1: set_config(C_MAX, C_MIN, FILL_NONZERO, 1'b0);
        2: set_config('0, '0, FILL_EVEN_ODD, 1'b1);
        3: set_config(C_MIN, C_MIN, FILL_NONZERO, 1'b1);
        default: set_config(pick_query(), pick_query(), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 4) != 0);
      endcase
      phase_end = vertices_sent + $urandom_range(60, 200);
      while (vertices_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0)
          send_vertex($urandom, $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        else
          send_path();
      end
      wait_idle();
    end

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pipwt_pkg.sv
rtl/core/pipwt_in_if.sv
rtl/core/pipwt_out_if.sv
rtl/core/point_in_path_winding_test.sv
dv/pip_result_checker.sv
dv/testbench.sv
